/* hdl/spgc_pkg.sv */
package spgc_pkg;

    localparam int DEF_MAX_PERIODS   = 8;
    localparam int DEF_MAX_INTERVALS = 8;

    localparam logic [17:0] DAY_SECONDS = 18'd86400;
    localparam logic [4:0]  DIV_LAST    = 5'd16;

    localparam logic [1:0] MODE_HEADER   = 2'd0;
    localparam logic [1:0] MODE_INTERVAL = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  period_index;
        logic [2:0]  interval_index;
        logic [16:0] start_seconds;
        logic [9:0]  cycle_length;
        logic [9:0]  phase_offset;
        logic [3:0]  interval_total;
        logic [9:0]  green_begin;
        logic [9:0]  green_end;
        logic [16:0] time_stamp;
    } t_spgc_in;

    typedef struct packed {
        logic [10:0] seconds_to_green;
        logic        no_period;
    } t_spgc_out;

    typedef struct packed {
        logic [16:0] start;
        logic [9:0]  cycle;
        logic [9:0]  offset;
        logic [3:0]  count;
    } t_period_rec;

    typedef struct packed {
        logic [9:0] green_begin;
        logic [9:0] green_end;
    } t_interval_rec;

endpackage

/* hdl/spgc_ram.sv */
module spgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/signal_plan_green_countdown.sv */
// Time-of-day signal plan with green countdown.
//
// Items enter on i_item when start is high and busy is low. A header load
// (mode 0) or interval load (mode 1) writes one entry and leaves busy low.
// A query (mode 2) raises busy while the plan is scanned; mode 3 is dropped.
// The register active_periods is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle, which the block
// itself does not enforce.
// A query result shows on o_result with o_strobe high for a single cycle;
// busy falls on that same cycle, so the next item can be taken at once.
// The receiver cannot stall. A query with no periods is answered without a
// scan; else each period scanned takes one read of the period memory (S_HDR,
// S_NXT), and the period that holds the time stamp then runs a bit-serial
// modulo (S_MOD), a correction (S_FIX) and one read of the interval memory
// per green interval (S_IV). Reset clears active_periods, the sequencer and
// the strobe; plan memories hold garbage until loaded and get no clearing
// pass.
module signal_plan_green_countdown
    import spgc_pkg::*;
#(
    parameter int MAX_PERIODS   = DEF_MAX_PERIODS,
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_spgc_in   i_item,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    output logic       o_strobe,
    output t_spgc_out  o_result
);

    localparam int IDEPTH = MAX_PERIODS * MAX_INTERVALS;
    localparam int PAW    = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int IIW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int NW     = $clog2(MAX_PERIODS + 1);
    localparam int KW     = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_NXT,
        S_MOD,
        S_FIX,
        S_IV
    } t_state;

    t_state        r_state;
    logic [3:0]    r_active;
    logic          r_strobe;
    t_spgc_out     r_result;

    logic [16:0]   r_t;
    logic [PAW-1:0] r_idx;
    logic [PAW-1:0] r_last;
    logic [16:0]   r_start0;
    t_period_rec   r_cur;
    logic [IIW-1:0] r_j;
    logic [IIW-1:0] r_klast;
    logic          r_neg;
    logic [16:0]   r_div;
    logic [9:0]    r_rem;
    logic [4:0]    r_cnt;
    logic [9:0]    r_pos;
    logic [10:0]   r_best;
    logic          r_green;

    logic          accept;
    logic          p_we;
    logic          iv_we;
    logic [PAW-1:0] p_waddr;
    logic [PAW-1:0] p_raddr;
    logic [IAW-1:0] iv_waddr;
    logic [IAW-1:0] iv_raddr;
    logic [PAW-1:0] p_next;
    logic [IIW-1:0] j_next;
    t_period_rec   p_wdata;
    t_period_rec   p_rdata;
    t_interval_rec iv_wdata;
    t_interval_rec iv_rdata;

    logic [NW-1:0] n_sat;
    logic [KW-1:0] k_sat;
    logic [17:0]   span_end;
    logic          in_span;
    logic [10:0]   rem_sh;
    logic [9:0]    n_rem;
    logic [9:0]    n_pos;
    logic          hit;
    logic [10:0]   wait_s;
    logic [10:0]   n_best;
    logic          n_green;
    logic          n_strobe;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign n_sat = (r_active > MAX_PERIODS) ? NW'(MAX_PERIODS) : NW'(r_active);
    assign k_sat = (r_cur.count > MAX_INTERVALS) ? KW'(MAX_INTERVALS) : KW'(r_cur.count);

    assign n_strobe = ((r_state == S_IDLE) && accept && (i_item.mode == MODE_QUERY)
                       && (n_sat == '0))
                      || ((r_state == S_NXT) && !in_span && (r_idx == r_last))
                      || ((r_state == S_IV) && (r_j == r_klast));

    always_comb begin
        p_we     = accept && (i_item.mode == MODE_HEADER)
                   && (32'(i_item.period_index) < MAX_PERIODS);
        iv_we    = accept && (i_item.mode == MODE_INTERVAL)
                   && (32'(i_item.period_index) < MAX_PERIODS)
                   && (32'(i_item.interval_index) < MAX_INTERVALS);
        p_waddr  = PAW'(i_item.period_index);
        iv_waddr = IAW'(32'(i_item.period_index) * MAX_INTERVALS
                        + 32'(i_item.interval_index));
        p_wdata  = '{start:  i_item.start_seconds,
                     cycle:  i_item.cycle_length,
                     offset: i_item.phase_offset,
                     count:  i_item.interval_total};
        iv_wdata = '{green_begin: i_item.green_begin,
                     green_end:   i_item.green_end};

        p_next = (r_idx == r_last) ? r_idx : r_idx + 1'b1;
        j_next = (r_j == r_klast) ? r_j : r_j + 1'b1;

        unique case (r_state)
            S_IDLE:        p_raddr = '0;
            S_HDR, S_NXT:  p_raddr = p_next;
            default:       p_raddr = r_idx;
        endcase

        unique case (r_state)
            S_IV:    iv_raddr = IAW'(32'(r_idx) * MAX_INTERVALS + 32'(j_next));
            default: iv_raddr = IAW'(32'(r_idx) * MAX_INTERVALS);
        endcase
    end

    // span test
    always_comb begin
        span_end = (r_idx == r_last) ? ({1'b0, r_start0} + DAY_SECONDS)
                                     : {1'b0, p_rdata.start};
        in_span  = (r_t >= r_cur.start) && ({1'b0, r_t} <= span_end)
                   && (k_sat != '0);
    end

    // restoring modulo step and final cycle position
    always_comb begin
        rem_sh = {r_rem, r_div[16]};
        n_rem  = (rem_sh >= {1'b0, r_cur.cycle}) ? 10'(rem_sh - {1'b0, r_cur.cycle})
                                                  : rem_sh[9:0];
        priority if (r_cur.cycle == '0) begin
            n_pos = '0;
        end else if (r_neg && (r_rem != '0)) begin
            n_pos = r_cur.cycle - r_rem;
        end else if (r_neg) begin
            n_pos = '0;
        end else begin
            n_pos = r_rem;
        end
    end

    // interval evaluation
    always_comb begin
        hit    = (r_pos >= iv_rdata.green_begin) && (r_pos <= iv_rdata.green_end);
        wait_s = (r_pos < iv_rdata.green_begin)
                 ? ({1'b0, iv_rdata.green_begin} - {1'b0, r_pos})
                 : ({1'b0, r_cur.cycle} - {1'b0, r_pos} + {1'b0, iv_rdata.green_begin});
        n_best  = (wait_s < r_best) ? wait_s : r_best;
        n_green = r_green || hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.mode == MODE_QUERY)) begin
                        r_t    <= i_item.time_stamp;
                        r_idx  <= '0;
                        r_last <= PAW'(n_sat - 1'b1);
                        if (n_sat == '0) begin
                            r_result <= '{seconds_to_green: '0, no_period: 1'b1};
                        end else begin
                            r_state <= S_HDR;
                        end
                    end
                end
                S_HDR: begin
                    r_cur <= p_rdata;
                    if (r_idx == '0) begin
                        r_start0 <= p_rdata.start;
                    end
                    r_state <= S_NXT;
                end
                S_NXT: begin
                    priority if (in_span) begin
                        r_klast <= IIW'(k_sat - 1'b1);
                        r_neg   <= (r_t < {7'd0, r_cur.offset});
                        r_div   <= (r_t < {7'd0, r_cur.offset})
                                   ? ({7'd0, r_cur.offset} - r_t)
                                   : (r_t - {7'd0, r_cur.offset});
                        r_rem   <= '0;
                        r_cnt   <= DIV_LAST;
                        r_state <= S_MOD;
                    end else if (r_idx == r_last) begin
                        r_result <= '{seconds_to_green: '0, no_period: 1'b1};
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_HDR;
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[15:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_FIX;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIX: begin
                    r_pos   <= n_pos;
                    r_j     <= '0;
                    r_best  <= '1;
                    r_green <= 1'b0;
                    r_state <= S_IV;
                end
                S_IV: begin
                    r_best  <= n_best;
                    r_green <= n_green;
                    if (r_j == r_klast) begin
                        r_result <= '{seconds_to_green: n_green ? 11'd0 : n_best,
                                      no_period: 1'b0};
                        r_state  <= S_IDLE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    spgc_ram #(
        .WIDTH ($bits(t_period_rec)),
        .DEPTH (MAX_PERIODS)
    ) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    spgc_ram #(
        .WIDTH ($bits(t_interval_rec)),
        .DEPTH (IDEPTH)
    ) u_interval_ram (
        .i_clk   (i_clk),
        .i_we    (iv_we),
        .i_waddr (iv_waddr),
        .i_wdata (iv_wdata),
        .i_raddr (iv_raddr),
        .o_rdata (iv_rdata)
    );

endmodule

/* hdl/spgc_checker.sv */
module spgc_checker
    import spgc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_spgc_in  i_item,
    input logic      o_strobe,
    input t_spgc_out o_result
);

    a_no_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.no_period |-> o_result.seconds_to_green == '0)
        else $error("no_period result carries a nonzero wait");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.mode != MODE_QUERY) |=> !busy)
        else $error("load or unused mode made the block busy");

    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.mode == MODE_QUERY) |=> busy || o_strobe)
        else $error("query transfer neither started a scan nor answered");

    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe)
        else $error("scan ended without a result");

endmodule

bind signal_plan_green_countdown spgc_checker u_spgc_checker (.*);

/* test/spgc_checker.sv */
module spgc_scoreboard
    import spgc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  t_spgc_in  item,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic      strobe,
    input  t_spgc_out result,
    output int        fails,
    output int        outstanding
);

    t_period_rec   plan [DEF_MAX_PERIODS];
    t_interval_rec greens [DEF_MAX_PERIODS][DEF_MAX_INTERVALS];
    logic [3:0]    periods_in_use = '0;
    t_spgc_out     countdown_q [$];

    initial begin
        fails = 0;
        outstanding = 0;
    end

    function automatic int unsigned cycle_pos(int unsigned t, int unsigned off,
                                              int unsigned c);
        int unsigned r;
        if (c == 0) return 0;
        if (t >= off) return (t - off) % c;
        r = (off - t) % c;
        return (r == 0) ? 0 : c - r;
    endfunction

    function automatic t_spgc_out green_countdown(t_spgc_in q);
        t_spgc_out   r;
        int unsigned t, n, span_end, k, c, pos, b, e, w, best;
        bit          green;
        r.seconds_to_green = '0;
        r.no_period = 1'b1;
        t = q.time_stamp;
        n = (periods_in_use > DEF_MAX_PERIODS) ? DEF_MAX_PERIODS : periods_in_use;
        for (int i = 0; i < n; i++) begin
            span_end = (i == n - 1) ? plan[0].start + DAY_SECONDS : plan[i + 1].start;
            if (t < plan[i].start || t > span_end) continue;
            k = plan[i].count;
            if (k > DEF_MAX_INTERVALS) k = DEF_MAX_INTERVALS;
            if (k == 0) continue;
            c = plan[i].cycle;
            pos = cycle_pos(t, plan[i].offset, c);
            best = 32'hFFFF_FFFF;
            green = 1'b0;
            for (int j = 0; j < k; j++) begin
                b = greens[i][j].green_begin;
                e = greens[i][j].green_end;
                if (pos >= b && pos <= e) green = 1'b1;
                w = (pos < b) ? b - pos : c - pos + b;
                if (w < best) best = w;
            end
            r.seconds_to_green = green ? 11'd0 : 11'(best);
            r.no_period = 1'b0;
            return r;
        end
        return r;
    endfunction

    task automatic flag(string msg);
        fails++;
        if (fails <= 10) $display("%s", msg);
    endtask

    always @(posedge clk) begin
        t_spgc_out want;
        if (!rst_n) begin
            periods_in_use = '0;
        end else begin
            if (strobe) begin
                if (countdown_q.size() == 0) begin
                    flag($sformatf("unexpected result: wait %0d no_period %0b",
                                   result.seconds_to_green, result.no_period));
                end else begin
                    want = countdown_q.pop_front();
                    if (result.seconds_to_green !== want.seconds_to_green ||
                        result.no_period !== want.no_period)
                        flag($sformatf({"countdown mismatch: expected wait %0d ",
                                        "no_period %0b, got wait %0d no_period %0b"},
                                       want.seconds_to_green, want.no_period,
                                       result.seconds_to_green, result.no_period));
                end
            end
            if (start && !busy) begin
                case (item.mode)
                    MODE_HEADER: begin
                        plan[item.period_index] = '{start: item.start_seconds,
                                                    cycle: item.cycle_length,
                                                    offset: item.phase_offset,
                                                    count: item.interval_total};
                    end
                    MODE_INTERVAL: begin
                        greens[item.period_index][item.interval_index] =
                            '{green_begin: item.green_begin, green_end: item.green_end};
                    end
                    MODE_QUERY: begin
                        countdown_q = {countdown_q, green_countdown(item)};
                    end
                    default: ;
                endcase
            end
            if (cfg_we) periods_in_use = cfg_wdata;
        end
        outstanding = countdown_q.size();
    end

endmodule

/* test/signal_plan_green_countdown_tb.sv */
module signal_plan_green_countdown_tb;
    import spgc_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 50;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_spgc_in   item = '0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic       strobe;
    t_spgc_out  result;
    int         fails;
    int         outstanding;
    int         quiet_cycles = 0;
    int         idle_pct = 0;
    logic [16:0] plan_start [DEF_MAX_PERIODS];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    signal_plan_green_countdown DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    spgc_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .strobe     (strobe),
        .result     (result),
        .fails      (fails),
        .outstanding(outstanding)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_spgc_in noise_item();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[$bits(t_spgc_in)-1:0];
    endfunction

    function automatic t_spgc_in header_item(logic [2:0] pi, logic [16:0] s,
                                             logic [9:0] c, logic [9:0] off,
                                             logic [3:0] total);
        t_spgc_in x;
        x = noise_item();
        x.mode = MODE_HEADER;
        x.period_index = pi;
        x.start_seconds = s;
        x.cycle_length = c;
        x.phase_offset = off;
        x.interval_total = total;
        return x;
    endfunction

    function automatic t_spgc_in interval_item(logic [2:0] pi, logic [2:0] ii,
                                               t_interval_rec g);
        t_spgc_in x;
        x = noise_item();
        x.mode = MODE_INTERVAL;
        x.period_index = pi;
        x.interval_index = ii;
        x.green_begin = g.green_begin;
        x.green_end = g.green_end;
        return x;
    endfunction

    function automatic t_spgc_in query_item(int t);
        t_spgc_in x;
        x = noise_item();
        x.mode = MODE_QUERY;
        if (t < 0) t = 0;
        if (t > 131071) t = 131071;
        x.time_stamp = 17'(t);
        return x;
    endfunction

    function automatic logic [9:0] rand_cycle();
        case ($urandom_range(9))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd1;
            default: return 10'($urandom_range(2, 400));
        endcase
    endfunction

    function automatic logic [3:0] rand_total();
        case ($urandom_range(9))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic t_interval_rec rand_green();
        t_interval_rec g;
        int unsigned   r;
        r = $urandom_range(99);
        g.green_begin = 10'($urandom_range(0, 400));
        if (r < 10) begin
            g.green_begin = 10'($urandom_range(0, 1023));
            g.green_end = 10'($urandom_range(0, 1023));
        end else if (r < 25) begin
            g.green_end = 10'($urandom_range(0, g.green_begin));
        end else begin
            g.green_end = g.green_begin + 10'($urandom_range(0, 120));
        end
        return g;
    endfunction

    function automatic logic [3:0] rand_active();
        case ($urandom_range(9))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic int pick_time();
        int unsigned r;
        int          i;
        r = $urandom_range(99);
        i = $urandom_range(DEF_MAX_PERIODS - 1);
        if (r < 40) return plan_start[i] + $urandom_range(0, 3000);
        if (r < 55) return int'(plan_start[i]) + int'($urandom_range(0, 2)) - 1;
        if (r < 65) return int'(plan_start[0]) + 86400 + int'($urandom_range(0, 2)) - 1;
        return $urandom_range(0, 131071);
    endfunction

    function automatic t_spgc_in random_item();
        t_spgc_in    x;
        int unsigned r;
        logic [2:0]  pi;
        logic [16:0] s;
        r = $urandom_range(99);
        pi = 3'($urandom_range(7));
        if (r < 68) begin
            x = query_item(pick_time());
        end else if (r < 78) begin
            s = $urandom_range(1) ? plan_start[pi] : 17'($urandom_range(0, 86399));
            x = header_item(pi, s, rand_cycle(), 10'($urandom_range(0, 1023)),
                            rand_total());
        end else if (r < 95) begin
            x = interval_item(pi, 3'($urandom_range(7)), rand_green());
        end else begin
            x = noise_item();
            x.mode = MODE_UNUSED;
        end
        return x;
    endfunction

    task automatic transfer(input t_spgc_in x);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (x.mode == MODE_HEADER) plan_start[x.period_index] = x.start_seconds;
        start <= 1'b1;
        item <= x;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [3:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_plan();
        int s;
        s = $urandom_range(0, 20000);
        for (int p = 0; p < DEF_MAX_PERIODS; p++) begin
            transfer(header_item(3'(p), 17'(s), rand_cycle(),
                                 10'($urandom_range(0, 1023)), rand_total()));
            s = s + $urandom_range(0, 9000);
            if (s > 86399) s = 86399;
        end
        for (int p = 0; p < DEF_MAX_PERIODS; p++)
            for (int j = 0; j < DEF_MAX_INTERVALS; j++)
                transfer(interval_item(3'(p), 3'(j), rand_green()));
    endtask

    initial begin
        int idle_plan [3] = '{24, 88, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        transfer(query_item(0));
        transfer(query_item(131071));
        load_plan();
        write_cfg(4'(DEF_MAX_PERIODS));
        transfer(header_item(3'd2, plan_start[2], 10'd0, 10'd0, 4'd2));
        transfer(header_item(3'd3, plan_start[3], 10'd100, 10'd5, 4'd0));
        transfer(header_item(3'd4, plan_start[4], 10'd1023, 10'd1023, 4'd15));
        transfer(interval_item(3'd5, 3'd0, '{green_begin: 10'd500, green_end: 10'd100}));
        for (int p = 0; p < DEF_MAX_PERIODS; p++) transfer(query_item(plan_start[p] + 1));
        transfer(query_item(plan_start[0] + 86400));
        transfer(query_item(plan_start[0] + 86401));
        transfer(query_item(131071));
        transfer(query_item(0));
        transfer('{mode: MODE_UNUSED, default: '1});
        write_cfg(4'd15);
        transfer(query_item(plan_start[7] + 10));
        write_cfg(4'd1);
        transfer(query_item(plan_start[0] + 50000));
        write_cfg(4'd0);
        transfer(query_item(plan_start[0]));

        foreach (idle_plan[ph]) begin
            idle_pct = idle_plan[ph];
            for (int blk = 0; blk < 6; blk++) begin
                write_cfg(rand_active());
                repeat (60) transfer(random_item());
            end
        end

        drain();
        if (fails == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
